// ===== design/spq_pkg.sv =====
// shared types, codes and default sizes for the sorted priority queue
package spq_pkg;

  localparam int DEPTH_DEF     = 64;
  localparam int KEY_BITS_DEF  = 16;
  localparam int COST_BITS_DEF = 16;

  // request codes
  typedef enum logic [1:0] {
    REQ_PUSH     = 2'd0,
    REQ_POP      = 2'd1,
    REQ_CONTAINS = 2'd2,
    REQ_REMOVE   = 2'd3
  } req_t;

  // per-cycle commands broadcast to every cell
  typedef struct packed {
    logic prio_mode;
    logic pop_shift;
    logic load_match;
    logic scan;
    logic compact;
  } cell_ctrl_t;

  // flags of the insert wave travelling from cell to cell
  typedef struct packed {
    logic valid;
    logic shifting;
  } carry_t;

endpackage

// ===== design/spq_cell.sv =====
// one storage cell of the queue chain: holds an entry and trades with its neighbors
module spq_cell #(
  parameter int KEY_BITS  = spq_pkg::KEY_BITS_DEF,
  parameter int COST_BITS = spq_pkg::COST_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  spq_pkg::cell_ctrl_t  ctrl,
  input  logic                 occ,
  input  logic [KEY_BITS-1:0]  req_key,
  input  spq_pkg::carry_t      cin,
  input  logic [KEY_BITS-1:0]  cin_key,
  input  logic [COST_BITS-1:0] cin_cost,
  input  logic [KEY_BITS-1:0]  nxt_key,
  input  logic [COST_BITS-1:0] nxt_cost,
  input  logic                 nxt_keep,
  input  logic                 nxt_mark,
  input  logic                 prv_keep,
  output spq_pkg::carry_t      cout,
  output logic [KEY_BITS-1:0]  cout_key,
  output logic [COST_BITS-1:0] cout_cost,
  output logic [KEY_BITS-1:0]  ent_key,
  output logic [COST_BITS-1:0] ent_cost,
  output logic                 keep,
  output logic                 mark
);

  logic key_eq;

  assign key_eq = (ent_key == req_key);

  always_ff @(posedge clk) begin
    if (rst) begin
      cout <= '0;
      keep <= 1'b0;
      mark <= 1'b0;
    end else begin
      cout <= '0;
      // insert wave: settle in an empty slot, swap in, or pass along
      if (cin.valid) begin
        if (!occ) begin
          ent_key  <= cin_key;
          ent_cost <= cin_cost;
        end else if (cin.shifting || (ctrl.prio_mode && (ent_cost > cin_cost))) begin
          ent_key   <= cin_key;
          ent_cost  <= cin_cost;
          cout      <= '{valid: 1'b1, shifting: 1'b1};
          cout_key  <= ent_key;
          cout_cost <= ent_cost;
        end else begin
          cout      <= '{valid: 1'b1, shifting: 1'b0};
          cout_key  <= cin_key;
          cout_cost <= cin_cost;
        end
      end
      if (ctrl.pop_shift) begin
        ent_key  <= nxt_key;
        ent_cost <= nxt_cost;
      end
      if (ctrl.load_match) begin
        mark <= occ && key_eq;
        keep <= occ && !key_eq;
      end
      if (ctrl.scan) begin
        mark <= nxt_mark;
      end
      // hole pulls from the right, a cell whose entry moved left becomes a hole
      if (ctrl.compact) begin
        if (!keep) begin
          ent_key  <= nxt_key;
          ent_cost <= nxt_cost;
          keep     <= nxt_keep;
        end else if (!prv_keep) begin
          keep <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== design/sorted_priority_queue.sv =====
// top level of the sorted priority queue: sequencer around a chain of storage cells
//
//  channel   ports                                         direction  handshake
//  request   start, busy, req_type, node_key, node_cost    in         start & !busy
//  result    done, hit, out_key, out_cost, entry_count,    out        done, one cycle
//            overflow
//  config    priority_mode_we, priority_mode_wdata         in         write enable
//
//  pop, a push into an empty or full queue: result is registered on the transaction edge
//  other push: the insert wave moves one cell per cycle down the chain
//  contains / remove: match marks are shifted out of cell 0 one per cycle
//    while holes left by a remove bubble toward the tail
//  reset clears the entry count and sets priority mode; cell contents stay undefined
//  busy is high while a request is in flight; the receiver cannot stall results
module sorted_priority_queue #(
  parameter int DEPTH     = spq_pkg::DEPTH_DEF,
  parameter int KEY_BITS  = spq_pkg::KEY_BITS_DEF,
  parameter int COST_BITS = spq_pkg::COST_BITS_DEF,
  localparam int CNT_W    = $clog2(DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           req_type,
  input  logic [KEY_BITS-1:0]  node_key,
  input  logic [COST_BITS-1:0] node_cost,
  input  logic                 priority_mode_we,
  input  logic                 priority_mode_wdata,
  output logic                 done,
  output logic                 hit,
  output logic [KEY_BITS-1:0]  out_key,
  output logic [COST_BITS-1:0] out_cost,
  output logic [CNT_W-1:0]     entry_count,
  output logic                 overflow
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INSERT,
    ST_SCAN
  } state_t;

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  state_t              state;
  logic                prio_mode;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    remain;
  logic [CNT_W-1:0]    match_cnt;
  logic [CNT_W-1:0]    match_cnt_next;
  logic                is_remove;
  logic                accept;
  spq_pkg::req_t       req;
  spq_pkg::cell_ctrl_t ctrl;
  spq_pkg::carry_t     inj;

  // chain wires, one slot per cell
  logic [DEPTH-1:0]     occ;
  logic [KEY_BITS-1:0]  ent_key   [DEPTH];
  logic [COST_BITS-1:0] ent_cost  [DEPTH];
  logic                 keep      [DEPTH];
  logic                 mark      [DEPTH];
  spq_pkg::carry_t      carry     [DEPTH];
  logic [KEY_BITS-1:0]  carry_key [DEPTH];
  logic [COST_BITS-1:0] carry_cost[DEPTH];

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign req    = spq_pkg::req_t'(req_type);

  // new entry enters cell 0 on the transaction edge
  assign inj.valid    = accept && (req == spq_pkg::REQ_PUSH) && (count != FULL_CNT);
  assign inj.shifting = 1'b0;

  always_comb begin
    ctrl.prio_mode  = prio_mode;
    ctrl.pop_shift  = accept && (req == spq_pkg::REQ_POP) && (count != '0);
    ctrl.load_match = accept && ((req == spq_pkg::REQ_CONTAINS) ||
                                 (req == spq_pkg::REQ_REMOVE));
    ctrl.scan       = (state == ST_SCAN);
    ctrl.compact    = (state == ST_SCAN) && is_remove;
  end

  assign match_cnt_next = match_cnt + CNT_W'(mark[0]);

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      spq_pkg::carry_t      c_in;
      logic [KEY_BITS-1:0]  c_in_key;
      logic [COST_BITS-1:0] c_in_cost;
      logic [KEY_BITS-1:0]  n_key;
      logic [COST_BITS-1:0] n_cost;
      logic                 n_keep;
      logic                 n_mark;
      logic                 p_keep;

      // slot is live when it lies below the entry count
      assign occ[gi] = (CNT_W'(gi) < count);

      if (gi == 0) begin : g_head
        assign c_in      = inj;
        assign c_in_key  = node_key;
        assign c_in_cost = node_cost;
        assign p_keep    = 1'b1;
      end else begin : g_body
        assign c_in      = carry[gi-1];
        assign c_in_key  = carry_key[gi-1];
        assign c_in_cost = carry_cost[gi-1];
        assign p_keep    = keep[gi-1];
      end

      if (gi == DEPTH - 1) begin : g_tail
        assign n_key  = '0;
        assign n_cost = '0;
        assign n_keep = 1'b0;
        assign n_mark = 1'b0;
      end else begin : g_inner
        assign n_key  = ent_key[gi+1];
        assign n_cost = ent_cost[gi+1];
        assign n_keep = keep[gi+1];
        assign n_mark = mark[gi+1];
      end

      spq_cell #(
        .KEY_BITS (KEY_BITS),
        .COST_BITS(COST_BITS)
      ) u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctrl     (ctrl),
        .occ      (occ[gi]),
        .req_key  (node_key),
        .cin      (c_in),
        .cin_key  (c_in_key),
        .cin_cost (c_in_cost),
        .nxt_key  (n_key),
        .nxt_cost (n_cost),
        .nxt_keep (n_keep),
        .nxt_mark (n_mark),
        .prv_keep (p_keep),
        .cout     (carry[gi]),
        .cout_key (carry_key[gi]),
        .cout_cost(carry_cost[gi]),
        .ent_key  (ent_key[gi]),
        .ent_cost (ent_cost[gi]),
        .keep     (keep[gi]),
        .mark     (mark[gi])
      );
    end
  endgenerate

  // sequencer, entry count and registered result
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      prio_mode   <= 1'b1;
      count       <= '0;
      remain      <= '0;
      match_cnt   <= '0;
      is_remove   <= 1'b0;
      done        <= 1'b0;
      hit         <= 1'b0;
      out_key     <= '0;
      out_cost    <= '0;
      entry_count <= '0;
      overflow    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (priority_mode_we) begin
        prio_mode <= priority_mode_wdata;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            hit      <= 1'b0;
            out_key  <= '0;
            out_cost <= '0;
            overflow <= 1'b0;
            case (req)
              spq_pkg::REQ_PUSH: begin
                if (count == FULL_CNT) begin
                  // full queue, push dropped
                  done        <= 1'b1;
                  overflow    <= 1'b1;
                  entry_count <= count;
                end else if (count == '0) begin
                  // lands in cell 0 on this edge
                  done        <= 1'b1;
                  hit         <= 1'b1;
                  count       <= count + 1'b1;
                  entry_count <= count + 1'b1;
                end else begin
                  remain <= count;
                  state  <= ST_INSERT;
                end
              end
              spq_pkg::REQ_POP: begin
                done <= 1'b1;
                if (count != '0) begin
                  hit         <= 1'b1;
                  out_key     <= ent_key[0];
                  out_cost    <= ent_cost[0];
                  count       <= count - 1'b1;
                  entry_count <= count - 1'b1;
                end else begin
                  entry_count <= count;
                end
              end
              default: begin
                // contains or remove: marks were loaded on this edge
                remain    <= FULL_CNT;
                match_cnt <= '0;
                is_remove <= (req == spq_pkg::REQ_REMOVE);
                state     <= ST_SCAN;
              end
            endcase
          end
        end
        ST_INSERT: begin
          // the wave reaches the first free slot on the last step
          if (remain == CNT_W'(1)) begin
            done        <= 1'b1;
            hit         <= 1'b1;
            count       <= count + 1'b1;
            entry_count <= count + 1'b1;
            state       <= ST_IDLE;
          end else begin
            remain <= remain - 1'b1;
          end
        end
        ST_SCAN: begin
          match_cnt <= match_cnt_next;
          if (remain == CNT_W'(1)) begin
            done  <= 1'b1;
            hit   <= (match_cnt_next != '0);
            state <= ST_IDLE;
            if (is_remove) begin
              count       <= count - match_cnt_next;
              entry_count <= count - match_cnt_next;
            end else begin
              entry_count <= count;
            end
          end else begin
            remain <= remain - 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT)
    else $error("entry count above depth");

  a_ovf_no_hit: assert property (@(posedge clk) disable iff (rst)
    done && overflow |-> !hit && (entry_count == FULL_CNT))
    else $error("overflow reported with hit or non-full queue");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while still busy");

  a_insert_room: assert property (@(posedge clk) disable iff (rst)
    (state == ST_INSERT) |-> (count != '0) && (count != FULL_CNT))
    else $error("insert wave running on empty or full queue");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    done && hit && $past(state == ST_INSERT) |-> count == $past(count) + 1'b1)
    else $error("push did not grow the queue by one");

endmodule
